>>> src/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared sizes, codes and controller/datapath interface types of the
// sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  // Request kinds as seen on req_type
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_POPPED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Operation the controller orders for the held request
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_POP,
    OP_REFUSE_FULL,
    OP_REFUSE_EMPTY
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;   // capture the incoming request
    logic exec;   // carry out op on the queue and fill the result register
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic is_pop;  // held request is a pop
    logic full;
    logic empty;
  } stat_t;

endpackage

`default_nettype wire

>>> src/spq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl
// Request sequencer: takes one request, orders the queue operation, then
// holds the result until it is taken.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  wire            clk,
  input  wire            rst,
  input  wire            in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire            out_stall,
  input  spq_pkg::stat_t stat,
  output spq_pkg::cmd_t  cmd
);
  import spq_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    cmd.op     = OP_INSERT;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.is_pop) begin
          cmd.op = stat.empty ? OP_REFUSE_EMPTY : OP_POP;
        end else begin
          cmd.op = stat.full ? OP_REFUSE_FULL : OP_INSERT;
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> src/spq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted entry row with parallel compare and shift, request hold register
// and result register.
// ----------------------------------------------------------------------------
module spq_datapath (
  input  wire                   clk,
  input  wire                   rst,
  input  spq_pkg::cmd_t         cmd,
  output spq_pkg::stat_t        stat,
  input  wire                   req_type,
  input  wire signed [31:0]     item_value,
  input  wire        [7:0]      item_priority,
  output logic       [1:0]      status,
  output logic signed [31:0]    out_value,
  output logic       [7:0]      out_priority,
  output logic       [4:0]      entry_count
);
  import spq_pkg::*;

  // Held request
  logic                     hold_type;
  logic [31:0]              hold_value;
  logic [PRIORITY_BITS-1:0] hold_pri;
  logic [31:0]              pri_wide;

  // Entry row, front at index 0; contents beyond count are don't-care
  logic [31:0]              ent_value [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] ent_pri   [QUEUE_DEPTH];
  logic [COUNT_BITS-1:0]    count;

  // Result register
  status_t                  res_status;
  logic [31:0]              res_value;
  logic [PRIORITY_BITS-1:0] res_pri;
  logic [COUNT_BITS-1:0]    res_count;
  logic [31:0]              res_pri_wide;
  logic [31:0]              res_count_wide;

  // At or behind the insert point: entry unused or priority not smaller
  logic [QUEUE_DEPTH-1:0]   behind;

  assign pri_wide = {24'd0, item_priority};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hold_type  <= req_type;
      hold_value <= item_value;
      hold_pri   <= pri_wide[PRIORITY_BITS-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      behind[i] = (COUNT_BITS'(i) >= count) || (ent_pri[i] >= hold_pri);
    end
  end

  assign stat.is_pop = (hold_type == REQ_POP);
  assign stat.full   = (count == COUNT_BITS'(QUEUE_DEPTH));
  assign stat.empty  = (count == '0);

  // Entry row update
  always_ff @(posedge clk) begin
    if (cmd.exec && cmd.op == OP_INSERT) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (i == 0) begin
          if (behind[0]) begin
            ent_value[0] <= hold_value;
            ent_pri[0]   <= hold_pri;
          end
        end else if (behind[i]) begin
          if (behind[i-1]) begin
            ent_value[i] <= ent_value[i-1];
            ent_pri[i]   <= ent_pri[i-1];
          end else begin
            ent_value[i] <= hold_value;
            ent_pri[i]   <= hold_pri;
          end
        end
      end
    end else if (cmd.exec && cmd.op == OP_POP) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        ent_value[i] <= ent_value[i+1];
        ent_pri[i]   <= ent_pri[i+1];
      end
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      case (cmd.op)
        OP_INSERT: count <= count + 1'b1;
        OP_POP:    count <= count - 1'b1;
        default:   count <= count;
      endcase
    end
  end

  // Result capture; only a pop carries entry data
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      case (cmd.op)
        OP_INSERT: begin
          res_status <= ST_INSERTED;
          res_value  <= '0;
          res_pri    <= '0;
          res_count  <= count + 1'b1;
        end
        OP_POP: begin
          res_status <= ST_POPPED;
          res_value  <= ent_value[0];
          res_pri    <= ent_pri[0];
          res_count  <= count - 1'b1;
        end
        OP_REFUSE_FULL: begin
          res_status <= ST_FULL;
          res_value  <= '0;
          res_pri    <= '0;
          res_count  <= count;
        end
        default: begin
          res_status <= ST_EMPTY;
          res_value  <= '0;
          res_pri    <= '0;
          res_count  <= count;
        end
      endcase
    end
  end

  assign res_pri_wide   = 32'(res_pri);
  assign res_count_wide = 32'(res_count);
  assign status         = res_status;
  assign out_value      = res_value;
  assign out_priority   = res_pri_wide[7:0];
  assign entry_count    = res_count_wide[4:0];

endmodule

`default_nettype wire

>>> src/sorted_priority_queue_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue of 16 entries kept sorted by ascending priority.
// ----------------------------------------------------------------------------
// Each request (insert or pop) passes through a capture step, in which it
// is taken into the hold register, an execute step, in which the whole entry
// row compares against the new priority and shifts at once, and an output
// step, in which the result is presented and held while it is stalled. The
// result is offered once the execute step has passed. A new request is taken
// only after the previous result has left. Equal priorities are served newest
// first. No clearing pass follows reset; the queue is empty at once.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire                req_type,
  input  wire signed [31:0]  item_value,
  input  wire        [7:0]   item_priority,
  output logic               out_valid,
  input  wire                out_stall,
  output logic       [1:0]   status,
  output logic signed [31:0] out_value,
  output logic       [7:0]   out_priority,
  output logic       [4:0]   entry_count
);
  import spq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .req_type      (req_type),
    .item_value    (item_value),
    .item_priority (item_priority),
    .status        (status),
    .out_value     (out_value),
    .out_priority  (out_priority),
    .entry_count   (entry_count)
  );

  // A taken request yields its result once the execute state has passed
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> ##2 out_valid)
    else $error("result not presented two cycles after request");

  // No new request while a result waits
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request taken while result pending");

  // Only a pop carries entry data
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_POPPED) |-> (out_value == 0 && out_priority == 0))
    else $error("nonzero data on a result without a popped entry");

  // Count never exceeds the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_count <= 5'(QUEUE_DEPTH)))
    else $error("entry count above queue depth");

endmodule

`default_nettype wire
